// ===== rtl/bir_pkg.sv =====
// Shared types and constants for the branch instruction relocator.
package bir_pkg;

  localparam int unsigned AddressBitsDefault = 64;
  localparam int unsigned FieldAddressBits   = 64;

  localparam logic [5:0] OPC_BRANCH      = 6'd18;
  localparam logic [5:0] OPC_BRANCH_COND = 6'd16;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_RANGE      = 2'd1;
  localparam logic [1:0] STATUS_NOT_BRANCH = 2'd2;

  typedef struct packed {
    logic [31:0]                   instruction_word;
    logic [FieldAddressBits-1:0]   source_address;
    logic [FieldAddressBits-1:0]   dest_address;
  } in_word_t;

  typedef struct packed {
    logic [31:0]                   new_instruction;
    logic [FieldAddressBits-1:0]   abs_target;
    logic [1:0]                    status;
  } out_word_t;

  typedef struct packed {
    logic is_branch;
    logic is_cond;
    logic absolute;
  } dec_ctl_t;

endpackage

// ===== rtl/branch_instruction_relocator.sv =====
// Top level of the branch instruction relocator.
//
// Usage: present a word on request and raise start. The word is taken at
// any rising edge where start is high and busy is low; busy is never
// raised, so one word can be taken every cycle.
// request carries the instruction word, the source address and the
// destination address. The word passes through the input register and then
// the result register, and the result word is shown on result with done
// high for exactly one cycle.
// Throughput is one word per cycle; one
// combinational pass of decode, target add, offset subtract and range
// check sits between the two registers.
// Address arithmetic wraps at ADDRESS_BITS; higher address bits are
// ignored and abs_target is zero above ADDRESS_BITS.
// Reset (rst, synchronous, active high) drops all words in flight and
// clears done. The receiver cannot stall: each result is shown once.
module branch_instruction_relocator #(
  parameter int unsigned ADDRESS_BITS = bir_pkg::AddressBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  bir_pkg::in_word_t  request,
  output logic               done,
  output bir_pkg::out_word_t result
);

  logic                    in_valid;
  bir_pkg::in_word_t       in_reg;
  bir_pkg::dec_ctl_t       ctl;
  logic [ADDRESS_BITS-1:0] target;
  bir_pkg::out_word_t      res_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      in_valid <= start && !busy;
      done     <= in_valid;
    end
    if (start && !busy) begin
      in_reg <= request;
    end
    if (in_valid) begin
      result <= res_next;
    end
  end

  bir_decode #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_decode (
    .word   (in_reg.instruction_word),
    .src    (in_reg.source_address[ADDRESS_BITS-1:0]),
    .ctl    (ctl),
    .target (target)
  );

  bir_encode #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_encode (
    .word   (in_reg.instruction_word),
    .ctl    (ctl),
    .target (target),
    .dst    (in_reg.dest_address[ADDRESS_BITS-1:0]),
    .res    (res_next)
  );

endmodule

// ===== rtl/bir_decode.sv =====
// Branch form decode and absolute target computation.
module bir_decode #(
  parameter int unsigned ADDRESS_BITS = bir_pkg::AddressBitsDefault
) (
  input  logic [31:0]             word,
  input  logic [ADDRESS_BITS-1:0] src,
  output bir_pkg::dec_ctl_t       ctl,
  output logic [ADDRESS_BITS-1:0] target
);

  logic [5:0]              opc;
  logic [ADDRESS_BITS-1:0] disp_u;
  logic [ADDRESS_BITS-1:0] disp_c;
  logic [ADDRESS_BITS-1:0] disp;
  logic [ADDRESS_BITS-1:0] base;

  assign opc    = word[31:26];
  assign disp_u = {{(ADDRESS_BITS-26){word[25]}}, word[25:2], 2'b00};
  assign disp_c = {{(ADDRESS_BITS-16){word[15]}}, word[15:2], 2'b00};

  always_comb begin
    ctl.is_branch = (opc == bir_pkg::OPC_BRANCH) || (opc == bir_pkg::OPC_BRANCH_COND);
    ctl.is_cond   = (opc == bir_pkg::OPC_BRANCH_COND);
    ctl.absolute  = word[1];
  end

  assign disp   = ctl.is_cond ? disp_c : disp_u;
  assign base   = ctl.absolute ? '0 : src;
  assign target = ctl.is_branch ? (disp + base) : '0;

endmodule

// ===== rtl/bir_encode.sv =====
// Offset computation, range check and branch word rebuild.
module bir_encode #(
  parameter int unsigned ADDRESS_BITS = bir_pkg::AddressBitsDefault
) (
  input  logic [31:0]             word,
  input  bir_pkg::dec_ctl_t       ctl,
  input  logic [ADDRESS_BITS-1:0] target,
  input  logic [ADDRESS_BITS-1:0] dst,
  output bir_pkg::out_word_t      res
);

  logic [ADDRESS_BITS-1:0] offset;
  logic                    aligned;
  logic                    fits_u;
  logic                    fits_c;
  logic                    fits;

  assign offset  = ctl.absolute ? target : (target - dst);
  assign aligned = (offset[1:0] == 2'b00);
  assign fits_u  = (&offset[ADDRESS_BITS-1:25]) || !(|offset[ADDRESS_BITS-1:25]);
  assign fits_c  = (&offset[ADDRESS_BITS-1:15]) || !(|offset[ADDRESS_BITS-1:15]);
  assign fits    = aligned && (ctl.is_cond ? fits_c : fits_u);

  always_comb begin
    res.abs_target      = bir_pkg::FieldAddressBits'(target);
    res.new_instruction = '0;
    if (!ctl.is_branch) begin
      res.status = bir_pkg::STATUS_NOT_BRANCH;
    end else if (!fits) begin
      res.status = bir_pkg::STATUS_RANGE;
    end else begin
      res.status = bir_pkg::STATUS_OK;
      if (ctl.is_cond) begin
        res.new_instruction = {bir_pkg::OPC_BRANCH_COND, word[25:16], offset[15:2], word[1:0]};
      end else begin
        res.new_instruction = {bir_pkg::OPC_BRANCH, offset[25:2], word[1:0]};
      end
    end
  end

endmodule

// ===== rtl/bir_checker.sv =====
// Port-level checks for the branch instruction relocator, bound to the top level.
module bir_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input bir_pkg::in_word_t  request,
  input logic               done,
  input bir_pkg::out_word_t result
);

  logic [31:0] req_word;
  assign req_word = request.instruction_word;

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(rst, 2)) |-> (done == $past(start && !busy, 2)))
    else $error("done does not follow accepted word by two cycles");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == bir_pkg::STATUS_OK || result.status == bir_pkg::STATUS_RANGE
              || result.status == bir_pkg::STATUS_NOT_BRANCH))
    else $error("status code out of range");

  a_fail_zero_word: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != bir_pkg::STATUS_OK) |-> (result.new_instruction == 32'd0))
    else $error("rebuilt word not zero on failure");

  a_not_branch: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(rst, 2) && $past(start && !busy, 2)
     && $past(req_word[31:26], 2) != bir_pkg::OPC_BRANCH
     && $past(req_word[31:26], 2) != bir_pkg::OPC_BRANCH_COND)
    |-> (done && result.status == bir_pkg::STATUS_NOT_BRANCH && result.abs_target == '0))
    else $error("non-branch word not reported as such");

endmodule

bind branch_instruction_relocator bir_checker u_bir_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .request (request),
  .done    (done),
  .result  (result)
);

// ===== dv/branch_instruction_relocator_test.sv =====
// Self-checking testbench for the branch instruction relocator.
module branch_instruction_relocator_test;

  localparam int unsigned ADDR_BITS = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  bir_pkg::in_word_t request = '0;
  bir_pkg::out_word_t result;

  bir_pkg::in_word_t pending_words[$];
  bir_pkg::out_word_t expected_results[$];
  int unsigned idle_pct = 0;
  int unsigned mismatch_count = 0;

  branch_instruction_relocator #(
    .ADDRESS_BITS(ADDR_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decode the target, then rebuild the branch for the new address.
  function automatic bir_pkg::out_word_t relocate(bir_pkg::in_word_t req);
    logic [31:0] w;
    logic [63:0] mask;
    logic [63:0] src;
    logic [63:0] dst;
    logic [63:0] tgt;
    logic [63:0] ofs;
    logic absolute;
    bir_pkg::out_word_t r;
    w = req.instruction_word;
    mask = {64{1'b1}} >> (64 - ADDR_BITS);
    src = req.source_address & mask;
    dst = req.dest_address & mask;
    absolute = w[1];
    r = '0;
    r.status = bir_pkg::STATUS_OK;
    if (w[31:26] == bir_pkg::OPC_BRANCH) begin
      tgt = {{38{w[25]}}, w[25:2], 2'b00};
    end else if (w[31:26] == bir_pkg::OPC_BRANCH_COND) begin
      tgt = {{48{w[15]}}, w[15:2], 2'b00};
    end else begin
      r.status = bir_pkg::STATUS_NOT_BRANCH;
      return r;
    end
    if (!absolute) tgt = tgt + src;
    tgt = tgt & mask;
    ofs = absolute ? tgt : ((tgt - dst) & mask);
    r.abs_target = tgt;
    if (w[31:26] == bir_pkg::OPC_BRANCH) begin
      if (ofs[1:0] != 2'b00 || ((ofs + 64'h2000000) & mask) >= 64'h4000000) begin
        r.status = bir_pkg::STATUS_RANGE;
      end else begin
        r.new_instruction = 32'h48000000 | (w & 32'h3) | (ofs[31:0] & 32'h3FFFFFC);
      end
    end else begin
      if (ofs[1:0] != 2'b00 || ((ofs + 64'h8000) & mask) >= 64'h10000) begin
        r.status = bir_pkg::STATUS_RANGE;
      end else begin
        r.new_instruction = 32'h40000000 | (w & 32'h3FF0003) | (ofs[31:0] & 32'hFFFC);
      end
    end
    return r;
  endfunction

  // Mostly branches whose destination lies near the source, so that both
  // in-range and out-of-range offsets turn up; the rest keep random opcodes.
  function automatic bir_pkg::in_word_t random_request();
    bir_pkg::in_word_t req;
    logic [31:0] w;
    logic [63:0] delta;
    int unsigned pick;
    w = $urandom;
    pick = $urandom_range(0, 9);
    if (pick < 4) w[31:26] = bir_pkg::OPC_BRANCH;
    else if (pick < 8) w[31:26] = bir_pkg::OPC_BRANCH_COND;
    req.instruction_word = w;
    req.source_address = {$urandom, $urandom};
    delta = {$urandom, $urandom};
    case ($urandom_range(0, 7)) inside
      [0:1]: delta = {{38{delta[25]}}, delta[25:0]};
      [2:4]: delta = {{48{delta[15]}}, delta[15:0]};
      5: delta = '0;
      default: ;
    endcase
    if ($urandom_range(0, 3) != 0) delta[1:0] = 2'b00;
    req.dest_address = req.source_address + delta;
    return req;
  endfunction

  task automatic push_word(logic [31:0] w, logic [63:0] src, logic [63:0] dst);
    bir_pkg::in_word_t req;
    req.instruction_word = w;
    req.source_address = src;
    req.dest_address = dst;
    pending_words.push_back(req);
  endtask

  task automatic run_random_phase(int unsigned pct, int unsigned count);
    idle_pct = pct;
    repeat (count) pending_words.push_back(random_request());
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  // Driver: a new word goes out once the previous one was taken.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_results.push_back(relocate(request));
      if (!start || !busy) begin
        if (pending_words.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          request <= pending_words.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    bir_pkg::out_word_t exp_word;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result word %h", result);
        mismatch_count++;
      end else begin
        exp_word = expected_results.pop_front();
        if (result.new_instruction !== exp_word.new_instruction) begin
          $error("new_instruction: expected %h, got %h",
                 exp_word.new_instruction, result.new_instruction);
          mismatch_count++;
        end
        if (result.abs_target !== exp_word.abs_target) begin
          $error("abs_target: expected %h, got %h",
                 exp_word.abs_target, result.abs_target);
          mismatch_count++;
        end
        if (result.status !== exp_word.status) begin
          $error("status: expected %0d, got %0d", exp_word.status, result.status);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("branch_instruction_relocator test failed");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // not a branch: zero word, all ones, neighbors of both opcodes
    push_word(32'h0, 64'h0, 64'h0);
    push_word(32'hFFFFFFFF, {64{1'b1}}, {64{1'b1}});
    push_word({6'd17, 26'h3FFFFFF}, 64'h1000, 64'h2000);
    push_word({6'd19, 26'h0}, 64'h1000, 64'h1000);
    // unconditional: extreme displacements, absolute with link
    push_word({bir_pkg::OPC_BRANCH, 26'h1FFFFFC}, 64'h0, 64'h0);
    push_word({bir_pkg::OPC_BRANCH, 26'h2000000}, 64'h0, 64'h0);
    push_word({bir_pkg::OPC_BRANCH, 26'h3FFFFFF}, {64{1'b1}}, {64{1'b1}});
    push_word({bir_pkg::OPC_BRANCH, 26'h2000003}, 64'h0, 64'h1234);
    // unconditional: offset at and just past both range edges
    push_word({bir_pkg::OPC_BRANCH, 26'h0}, 64'h40000000, 64'h40000000 - 64'h1FFFFFC);
    push_word({bir_pkg::OPC_BRANCH, 26'h0}, 64'h40000000, 64'h40000000 - 64'h2000000);
    push_word({bir_pkg::OPC_BRANCH, 26'h0}, 64'h40000000, 64'h40000000 + 64'h2000000);
    push_word({bir_pkg::OPC_BRANCH, 26'h1}, 64'h40000000, 64'h40000000 + 64'h2000004);
    // misaligned source
    push_word({bir_pkg::OPC_BRANCH, 26'h0}, 64'h1, 64'h0);
    push_word({bir_pkg::OPC_BRANCH_COND, 26'h0}, 64'h2, 64'h0);
    // conditional: condition fields kept, extremes of displacement
    push_word({bir_pkg::OPC_BRANCH_COND, 26'h3FF7FFC}, 64'h0, 64'h0);
    push_word({bir_pkg::OPC_BRANCH_COND, 26'h3FF8001}, 64'h5000, 64'h5000);
    push_word({bir_pkg::OPC_BRANCH_COND, 26'h000FFFE}, 64'h0, {64{1'b1}});
    push_word({bir_pkg::OPC_BRANCH_COND, 26'h0}, 64'h9000, 64'h9000 - 64'h7FFC);
    push_word({bir_pkg::OPC_BRANCH_COND, 26'h0}, 64'h9000, 64'h9000 - 64'h8000);
    push_word({bir_pkg::OPC_BRANCH_COND, 26'h0}, 64'h9000, 64'h9000 + 64'h8000);
    push_word({bir_pkg::OPC_BRANCH_COND, 26'h0}, 64'h9000, 64'h9000 + 64'h8004);
    // wrap through the top of the address space
    push_word({bir_pkg::OPC_BRANCH, 26'h8}, 64'hFFFFFFFFFFFFFFFC, 64'h0);
    push_word({bir_pkg::OPC_BRANCH_COND, 26'hFFF8}, 64'h4, 64'hFFFFFFFFFFFFFFF0);
    while (pending_words.size() != 0) @(posedge clk);

    run_random_phase(0, 225);
    run_random_phase(51, 225);
    run_random_phase(0, 225);
    run_random_phase(24, 225);

    while (start || expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("branch_instruction_relocator test passed");
    end else begin
      $display("branch_instruction_relocator test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bir_pkg.sv
rtl/bir_decode.sv
rtl/bir_encode.sv
rtl/branch_instruction_relocator.sv
rtl/bir_checker.sv
dv/branch_instruction_relocator_test.sv
